// ----- rtl/ttpm_pkg.sv -----
// Shared types and constants for the thrust to PWM mapper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ttpm_pkg;

  localparam int NumThr = 6;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LIMIT_EN  = 3'd0,
    REG_SINGLE    = 3'd1,
    REG_TOTAL     = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_DEADBAND  = 3'd4
  } reg_idx_t;

  localparam logic [10:0] PwmNeutral = 11'd1500;
  localparam logic [10:0] PwmLow     = 11'd1000;
  localparam logic [10:0] PwmHigh    = 11'd2000;
  localparam logic [10:0] LedLow     = 11'd1100;
  localparam logic [10:0] LedHigh    = 11'd1900;
  localparam logic [16:0] TickMax    = 17'd131071;

  // One job handed from the front part to the back part.
  typedef struct packed {
    logic [NumThr-1:0][13:0] thr;
    logic [10:0]             led_r;
    logic [10:0]             led_l;
    logic                    timed;
  } job_t;

  typedef struct packed {
    logic        limit_en;
    logic [12:0] single_lim;
    logic [15:0] total_lim;
    logic [12:0] deadband;
  } cfg_t;

  // Cubic coefficients at scale 2^20; row = {cw, negative}.
  function automatic logic signed [31:0] coef(input logic [1:0] row, input logic [1:0] k);
    logic signed [31:0] c;
    c = '0;
    unique case ({row, k})
      4'b00_00: c = -32'sd1573;
      4'b00_01: c = 32'sd180775;
      4'b00_10: c = -32'sd12515803;
      4'b00_11: c = 32'sd1537107558;
      4'b01_00: c = -32'sd3670;
      4'b01_01: c = -32'sd312581;
      4'b01_10: c = -32'sd16222519;
      4'b01_11: c = 32'sd1606837862;
      4'b10_00: c = 32'sd1573;
      4'b10_01: c = -32'sd180775;
      4'b10_10: c = 32'sd12515803;
      4'b10_11: c = 32'sd1608620442;
      4'b11_00: c = 32'sd3670;
      4'b11_01: c = 32'sd312581;
      4'b11_10: c = 32'sd16222519;
      4'b11_11: c = 32'sd1538890138;
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/thrust_to_pwm_mapper_unit.sv -----
// Top level of the thrust to PWM mapper: front part, one-job queue, back part.
// Depends on ttpm_pkg, ttpm_front, ttpm_back.
//
// Input channel in_valid/in_stall carries cmd, thrust and light fields; an
// item is taken when in_valid is high and in_stall low. Commands and stops
// always give one result; ticks give one only past the timeout.
// Output channel out_valid/out_stall carries pwm_a..pwm_f, pwm_right,
// pwm_left and timed_out. The back part maps the six thrusts one after the
// other, one product term per cycle. With the limiter on, a clamp to the
// single limit, a magnitude sum and a check against the total limit come first
// and, when the total limit scales, a bit-serial divide per thruster. The back
// part takes a new job only when it is idle, once it has finished the last one.
// The front holds one job while the back works, so a second item is taken at
// once. While out_stall is high the last result holds in the output register
// and the back part waits before loading a new one. Reset gives zero thrusts,
// LEDs at 1100 and reset register values.
`timescale 1ns / 1ps
`default_nettype none
module thrust_to_pwm_mapper_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic        has_thrust,
  input  wire logic signed [13:0] thrust_a,
  input  wire logic signed [13:0] thrust_b,
  input  wire logic signed [13:0] thrust_c,
  input  wire logic signed [13:0] thrust_d,
  input  wire logic signed [13:0] thrust_e,
  input  wire logic signed [13:0] thrust_f,
  input  wire logic        has_lights,
  input  wire logic [15:0] light_right,
  input  wire logic [15:0] light_left,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      pwm_a,
  output logic [10:0]      pwm_b,
  output logic [10:0]      pwm_c,
  output logic [10:0]      pwm_d,
  output logic [10:0]      pwm_e,
  output logic [10:0]      pwm_f,
  output logic [10:0]      pwm_right,
  output logic [10:0]      pwm_left,
  output logic             timed_out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ttpm_pkg::cfg_t  cfg;
  logic [15:0]     timeout_ticks;
  ttpm_pkg::job_t  job;
  logic            job_valid, job_stall;
  logic [5:0][10:0] pwm;
  logic [5:0][13:0] thr_in;

  assign thr_in = {thrust_f, thrust_e, thrust_d, thrust_c, thrust_b, thrust_a};

  // Register file writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_en <= 1'b0;
      cfg.single_lim <= 13'd7680;
      cfg.total_lim <= 16'd20517;
      cfg.deadband <= 13'd102;
      timeout_ticks <= 16'd1000;
    end else if (cfg_we) begin
      unique case (ttpm_pkg::reg_idx_t'(cfg_index))
        ttpm_pkg::REG_LIMIT_EN: cfg.limit_en <= cfg_data[0];
        ttpm_pkg::REG_SINGLE:   cfg.single_lim <= cfg_data[12:0];
        ttpm_pkg::REG_TOTAL:    cfg.total_lim <= cfg_data;
        ttpm_pkg::REG_TIMEOUT:  timeout_ticks <= cfg_data;
        ttpm_pkg::REG_DEADBAND: cfg.deadband <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  ttpm_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .has_thrust, .thr_in,
    .has_lights, .light_right, .light_left, .timeout_ticks,
    .job_valid, .job_stall, .job
  );

  ttpm_back u_back (
    .clk, .rst, .job_valid, .job_stall, .job, .cfg,
    .out_valid, .out_stall, .pwm, .pwm_right, .pwm_left, .timed_out
  );

  assign pwm_a = pwm[0];
  assign pwm_b = pwm[1];
  assign pwm_c = pwm[2];
  assign pwm_d = pwm[3];
  assign pwm_e = pwm[4];
  assign pwm_f = pwm[5];

endmodule
`default_nettype wire

// ----- rtl/ttpm_front.sv -----
// Front part: accepts items, keeps thrust/LED/tick state, issues jobs.
// Depends on ttpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttpm_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           cmd,
  input  wire logic                 has_thrust,
  input  wire logic [5:0][13:0]     thr_in,
  input  wire logic                 has_lights,
  input  wire logic [15:0]          light_right,
  input  wire logic [15:0]          light_left,
  input  wire logic [15:0]          timeout_ticks,
  output logic                      job_valid,
  input  wire logic                 job_stall,
  output ttpm_pkg::job_t            job
);

  logic [5:0][13:0] thrust_store;
  logic [10:0]      led_r, led_l;
  logic [16:0]      elapsed;
  logic [16:0]      elapsed_next;
  logic             acc;
  logic             emit;
  logic             timed;

  function automatic logic [10:0] clamp_led(input logic [15:0] v);
    if (v < 16'(ttpm_pkg::LedLow)) return ttpm_pkg::LedLow;
    if (v > 16'(ttpm_pkg::LedHigh)) return ttpm_pkg::LedHigh;
    return v[10:0];
  endfunction

  // Hold off while the last job has not been taken.
  assign in_stall = job_valid && job_stall;
  assign acc = in_valid && !in_stall;
  assign elapsed_next = (elapsed < ttpm_pkg::TickMax) ? elapsed + 17'd1 : elapsed;

  always_comb begin
    emit = 1'b0;
    timed = 1'b0;
    unique case (ttpm_pkg::cmd_t'(cmd))
      ttpm_pkg::CMD_PACKET: emit = 1'b1;
      ttpm_pkg::CMD_STOP:   emit = 1'b1;
      ttpm_pkg::CMD_TICK: begin
        emit = elapsed_next > {1'b0, timeout_ticks};
        timed = emit;
      end
      default: emit = 1'b0;
    endcase
  end

  // Update state and post a job.
  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_store <= '0;
      led_r <= ttpm_pkg::LedLow;
      led_l <= ttpm_pkg::LedLow;
      elapsed <= '0;
      job_valid <= 1'b0;
    end else begin
      if (acc && emit) job_valid <= 1'b1;
      else if (!job_stall) job_valid <= 1'b0;
      if (acc) begin
        unique case (ttpm_pkg::cmd_t'(cmd))
          ttpm_pkg::CMD_PACKET: begin
            elapsed <= '0;
            if (has_thrust) thrust_store <= thr_in;
            if (has_lights) begin
              led_r <= clamp_led(light_right);
              led_l <= clamp_led(light_left);
            end
            job.thr <= has_thrust ? thr_in : thrust_store;
            job.led_r <= has_lights ? clamp_led(light_right) : led_r;
            job.led_l <= has_lights ? clamp_led(light_left) : led_l;
          end
          ttpm_pkg::CMD_TICK: begin
            elapsed <= elapsed_next;
            if (emit) thrust_store <= '0;
            job.thr <= '0;
            job.led_r <= led_r;
            job.led_l <= led_l;
          end
          ttpm_pkg::CMD_STOP: begin
            thrust_store <= '0;
            led_r <= ttpm_pkg::LedLow;
            led_l <= ttpm_pkg::LedLow;
            job.thr <= '0;
            job.led_r <= ttpm_pkg::LedLow;
            job.led_l <= ttpm_pkg::LedLow;
          end
          default: ;
        endcase
        job.timed <= timed;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_stall |=> job_valid && $stable(job))
    else $error("job lost");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> job_valid)
    else $error("stall without job");
  a_tick_clear: assert property (@(posedge clk) disable iff (rst)
    acc && cmd == ttpm_pkg::CMD_PACKET |=> elapsed == '0)
    else $error("elapsed not cleared");

endmodule
`default_nettype wire

// ----- rtl/ttpm_back.sv -----
// Back part: limiter and cubic mapping, one product term per cycle, output register.
// Depends on ttpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ttpm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_stall,
  input  wire ttpm_pkg::job_t    job,
  input  wire ttpm_pkg::cfg_t    cfg,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [5:0][10:0]       pwm,
  output logic [10:0]            pwm_right,
  output logic [10:0]            pwm_left,
  output logic                   timed_out
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLAMP = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_X2    = 7'b0001000,
    S_X3    = 7'b0010000,
    S_POLY  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t           state;
  logic [5:0][14:0] w;          // sign-magnitude: bit14 sign, 14-bit magnitude
  logic [4:0][10:0] pw;         // finished pulses of thrusters 0..4
  logic [10:0]      led_r;
  logic [10:0]      led_l;
  logic             timed;
  logic [2:0]       idx;
  logic [16:0]      sum;
  logic [28:0]      num;        // mag * total_limit
  logic [28:0]      rem;
  logic [12:0]      quo;
  logic [4:0]       bitc;
  logic [1:0]       term;
  logic signed [27:0] x2;
  logic signed [40:0] x3;
  logic signed [79:0] acc;
  logic signed [79:0] prod;
  logic [10:0]      res;
  logic [10:0]      mapped;
  logic             fire;

  logic [13:0] cur_mag;
  logic        cur_neg;
  logic signed [14:0] xs;
  logic [1:0]  row;
  logic signed [31:0] cf;
  logic signed [79:0] one44;

  assign cur_mag = w[idx][13:0];
  assign cur_neg = w[idx][14];
  assign xs = cur_neg ? -$signed({1'b0, cur_mag}) : $signed({1'b0, cur_mag});
  assign row = {idx >= 3'd3, cur_neg};
  assign cf = ttpm_pkg::coef(row, term);
  assign one44 = 80'sd1 <<< 44;

  // One product term per cycle; each coefficient is cut to the bits it needs.
  always_comb begin
    unique case (term)
      2'd0: prod = 80'($signed(cf[13:0]) * x3);
      2'd1: prod = 80'($signed(cf[19:0]) * x2) <<< 8;
      2'd2: prod = 80'($signed(cf[24:0]) * xs) <<< 16;
      default: prod = 80'(cf) <<< 24;
    endcase
  end

  always_comb begin
    if (acc < $signed(80'(ttpm_pkg::PwmLow)) * one44) res = ttpm_pkg::PwmLow;
    else if (acc >= ($signed(80'(ttpm_pkg::PwmHigh)) + 80'sd1) * one44)
      res = ttpm_pkg::PwmHigh;
    else res = acc[54:44];
  end

  assign mapped = (cur_mag <= {1'b0, cfg.deadband}) ? ttpm_pkg::PwmNeutral : res;
  assign fire = (state == S_OUT) && (idx == 3'd5) && (!out_valid || !out_stall);

  assign job_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise on a finished result, drop once the beat is taken.
      if (fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid) begin
          for (int i = 0; i < 6; i++) begin
            w[i] <= {job.thr[i][13],
                     job.thr[i][13] ? 14'(14'd0 - job.thr[i]) : job.thr[i]};
          end
          led_r <= job.led_r;
          led_l <= job.led_l;
          timed <= job.timed;
          idx <= '0;
          sum <= '0;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          // With the limiter on, clamp each magnitude to the single limit.
          for (int i = 0; i < 6; i++) begin
            if (cfg.limit_en && w[i][13:0] > {1'b0, cfg.single_lim})
              w[i][13:0] <= {1'b0, cfg.single_lim};
          end
          idx <= '0;
          state <= S_DIV;
          sum <= '0;
          bitc <= '0;
        end
        S_DIV: begin
          // If limiting, sum first (bitc==0 sweeps idx), then divide if over total.
          if (!cfg.limit_en) begin
            idx <= '0; term <= '0; acc <= 80'sd1 <<< 43; state <= S_X2;
          end else if (bitc == 5'd0) begin
            sum <= sum + 17'(w[idx][13:0]);
            if (idx == 3'd5) begin idx <= '0; bitc <= 5'd1; end
            else idx <= idx + 3'd1;
          end else if (sum <= 17'(cfg.total_lim)) begin
            idx <= '0; term <= '0; acc <= 80'sd1 <<< 43; state <= S_X2;
          end else if (bitc == 5'd1) begin
            num <= 29'(cur_mag) * 29'(cfg.total_lim);
            rem <= '0; quo <= '0; bitc <= 5'd2;
          end else if (bitc < 5'd31) begin
            // restoring division, one bit per cycle
            if ({rem[27:0], num[28]} >= 29'(sum)) begin
              rem <= {rem[27:0], num[28]} - 29'(sum);
              quo <= {quo[11:0], 1'b1};
            end else begin
              rem <= {rem[27:0], num[28]};
              quo <= {quo[11:0], 1'b0};
            end
            num <= {num[27:0], 1'b0};
            bitc <= bitc + 5'd1;
          end else begin
            w[idx][13:0] <= {1'b0, quo};
            bitc <= 5'd1;
            if (idx == 3'd5) begin
              idx <= '0; term <= '0; acc <= 80'sd1 <<< 43; state <= S_X2;
            end else idx <= idx + 3'd1;
          end
        end
        S_X2: begin
          x2 <= 28'(xs * xs);
          state <= S_X3;
        end
        S_X3: begin
          x3 <= 41'(x2 * xs);
          term <= '0;
          state <= S_POLY;
        end
        S_POLY: begin
          acc <= acc + prod;
          term <= term + 2'd1;
          if (term == 2'd3) state <= S_OUT;
        end
        S_OUT: begin
          // Park finished pulses; load the output register only when it is free.
          if (idx != 3'd5) begin
            pw[idx] <= mapped;
            acc <= 80'sd1 <<< 43;
            idx <= idx + 3'd1;
            state <= S_X2;
          end else if (fire) begin
            pwm <= {mapped, pw};
            pwm_right <= led_r;
            pwm_left <= led_l;
            timed_out <= timed;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped");
  a_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({pwm, pwm_right, pwm_left, timed_out}))
    else $error("stalled result changed");
  a_take: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && job_valid |=> state == S_CLAMP)
    else $error("job not taken");

endmodule
`default_nettype wire
